### hdl/tksb_pkg.sv
// Shared types and codes for the top-k score board.
// Transaction payload structs, stored entry format, action codes, sequencer states.
// No dependencies.
package tksb_pkg;

    localparam int ID_W    = 32;
    localparam int SCORE_W = 32;
    localparam int SLOT_W  = 5;
    localparam int RANK_W  = 5;
    localparam int CNT_W   = 6;

    localparam logic [1:0] ACT_UPDATE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [ID_W-1:0]    player_id;
        logic [SCORE_W-1:0] new_score;
        logic [SLOT_W-1:0]  slot;
    } tksb_in_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic               ranked;
        logic [CNT_W-1:0]   entry_count;
        logic               read_valid;
        logic [ID_W-1:0]    read_id;
        logic [SCORE_W-1:0] read_score;
    } tksb_out_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } tksb_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_PLAN,
        ST_SHIFT,
        ST_SHIFT_TAIL,
        ST_WRITE,
        ST_READ,
        ST_FINISH
    } tksb_state_t;

endpackage

### hdl/tksb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module tksb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/tksb_cmp.sv
// Compare/count unit: looks for the id and counts entries ranking above the new score.
// One stored entry per strobe. Depends on tksb_pkg.
module tksb_cmp #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic                              valid,
    input  logic [$clog2(LIST_DEPTH)-1:0]     idx,
    input  tksb_pkg::tksb_entry_t             entry,
    input  logic [tksb_pkg::ID_W-1:0]         id,
    input  logic [tksb_pkg::SCORE_W-1:0]      score,
    output logic                              found,
    output logic [$clog2(LIST_DEPTH)-1:0]     pos,
    output logic [$clog2(LIST_DEPTH+1)-1:0]   cnt
);
    import tksb_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic          found_reg, found_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb begin
        found_next = found_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        if (start) begin
            found_next = 1'b0;
            pos_next   = '0;
            cnt_next   = '0;
        end else if (valid) begin
            if (!found_reg && entry.id == id) begin
                // skip the matching entry itself
                found_next = 1'b1;
                pos_next   = idx;
            end else if (found_reg) begin
                // ties after the old place fall below the moved entry
                if (entry.score > score) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end else begin
                if (entry.score >= score) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            found_reg <= found_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign found = found_reg;
    assign pos   = pos_reg;
    assign cnt   = cnt_reg;

endmodule

### hdl/top_k_score_board_top.sv
// An update scans the held entries (an empty list skips the scan), plans the placement, shifts
// the entries that move and writes the new one if it is kept; a read fetches its slot; clear and
// unknown codes go straight to the finish step. The next transaction is taken after the result is raised.
// The compare unit walks the RAM one entry per cycle under the sequencer.
// A result waiting on the output holds the next transaction only at its finish step.
// aresetn (synchronous, active low) empties the list; RAM contents are not cleared.
module top_k_score_board_top #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tksb_pkg::tksb_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tksb_pkg::tksb_out_t m_data
);
    import tksb_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    tksb_state_t state_reg, state_next;

    logic [1:0]         action_reg, action_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      end_reg, end_next;
    logic               down_reg, down_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               wpend_reg, wpend_next;
    logic [AW-1:0]      waddr_reg, waddr_next;
    logic               m_valid_reg, m_valid_next;
    tksb_out_t          out_reg, out_next;

    logic          accept;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    tksb_entry_t   wr_data, rd_data;
    logic          cmp_start;

    logic          found;
    logic [AW-1:0] pos;
    logic [CW-1:0] cnt;

    logic          keep;
    logic          need_shift;
    logic          plan_down;
    logic [CW-1:0] top_c;
    logic [CW-1:0] start_c;
    logic          slot_hit;
    logic          out_free;

    assign accept    = s_valid && s_ready;
    assign cmp_start = accept;
    assign out_free  = !m_valid_reg || m_ready;
    assign slot_hit  = {{CW{1'b0}}, slot_reg} < {{SLOT_W{1'b0}}, count_reg};
    assign keep      = found || (cnt < DEPTH_C);

    // placement plan from the scan results
    always_comb begin
        top_c      = (count_reg == DEPTH_C) ? DEPTH_C - 1'b1 : count_reg;
        plan_down  = 1'b1;
        need_shift = 1'b0;
        start_c    = '0;
        if (found) begin
            if (cnt < CW'(pos)) begin
                need_shift = 1'b1;
                start_c    = CW'(pos) - 1'b1;
            end else if (cnt > CW'(pos)) begin
                plan_down  = 1'b0;
                need_shift = 1'b1;
                start_c    = CW'(pos) + 1'b1;
            end
        end else if (keep && top_c > cnt) begin
            need_shift = 1'b1;
            start_c    = top_c - 1'b1;
        end
    end

    tksb_ram #(
        .WIDTH ($bits(tksb_entry_t)),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tksb_cmp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmp_start),
        .valid   (cmp_valid_reg),
        .idx     (cmp_idx_reg),
        .entry   (rd_data),
        .id      (id_reg),
        .score   (score_reg),
        .found   (found),
        .pos     (pos),
        .cnt     (cnt)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.action)
                        ACT_UPDATE: state_next = (count_reg == '0) ? ST_PLAN : ST_SCAN;
                        ACT_READ:   state_next = ST_READ;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN: begin
                if (CW'(ptr_reg) == count_reg - 1'b1) begin
                    state_next = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL: state_next = ST_PLAN;
            ST_PLAN: begin
                if (!keep) begin
                    state_next = ST_FINISH;
                end else if (need_shift) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_SHIFT: begin
                if (ptr_reg == end_reg) begin
                    state_next = ST_SHIFT_TAIL;
                end
            end
            ST_SHIFT_TAIL: state_next = ST_WRITE;
            ST_WRITE:      state_next = ST_FINISH;
            ST_READ:       state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        wr_en   = 1'b0;
        wr_addr = waddr_reg;
        wr_data = rd_data;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: rd_en = 1'b1;
            ST_SHIFT: begin
                rd_en = 1'b1;
                wr_en = wpend_reg;
            end
            ST_SHIFT_TAIL: wr_en = wpend_reg;
            ST_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = AW'(cnt);
                wr_data = '{id: id_reg, score: score_reg};
            end
            ST_READ: begin
                rd_en   = 1'b1;
                rd_addr = AW'(slot_reg);
            end
            ST_SCAN_TAIL, ST_PLAN, ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // datapath registers
    always_comb begin
        action_next    = action_reg;
        id_next        = id_reg;
        score_next     = score_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        down_next      = down_reg;
        cmp_valid_next = (state_reg == ST_SCAN);
        cmp_idx_next   = ptr_reg;
        wpend_next     = (state_reg == ST_SHIFT);
        waddr_next     = down_reg ? ptr_reg + 1'b1 : ptr_reg - 1'b1;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (accept) begin
            action_next = s_data.action;
            id_next     = s_data.player_id;
            score_next  = s_data.new_score;
            slot_next   = s_data.slot;
            ptr_next    = '0;
            if (s_data.action == ACT_CLEAR) begin
                count_next = '0;
            end
        end

        if (state_reg == ST_SCAN) begin
            ptr_next = ptr_reg + 1'b1;
        end

        if (state_reg == ST_PLAN) begin
            ptr_next  = AW'(start_c);
            end_next  = AW'(cnt);
            down_next = plan_down;
            if (!found && keep && count_reg != DEPTH_C) begin
                count_next = count_reg + 1'b1;
            end
        end

        if (state_reg == ST_SHIFT) begin
            ptr_next = down_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
        end

        if (state_reg == ST_FINISH && out_free) begin
            m_valid_next         = 1'b1;
            out_next             = '0;
            out_next.entry_count = CNT_W'(count_reg);
            if (action_reg == ACT_UPDATE && keep) begin
                out_next.ranked = 1'b1;
                out_next.rank   = RANK_W'(cnt);
            end
            if (action_reg == ACT_READ && slot_hit) begin
                out_next.read_valid = 1'b1;
                out_next.read_id    = rd_data.id;
                out_next.read_score = rd_data.score;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wpend_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            wpend_reg     <= wpend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        id_reg      <= id_next;
        score_reg   <= score_next;
        slot_reg    <= slot_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        down_reg    <= down_next;
        cmp_idx_reg <= cmp_idx_next;
        waddr_reg   <= waddr_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds list depth");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish state");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !wr_en)
        else $error("RAM write while idle");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> wr_addr != rd_addr)
        else $error("shift read and write hit the same slot");
`endif

endmodule

### dv/top_k_score_board_top_tb.sv
// Self-checking testbench for the top-k score board: directed table, then random episodes.
// A queue-based model of the ranked list predicts every result that the directed table does not give;
// idle and stall vary by phase. Depends on tksb_pkg and top_k_score_board_top.
module top_k_score_board_top_tb;
    import tksb_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 936;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int HOLD_AFTER   = 800;
    localparam int HOLD_LEN     = 400;

    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        tksb_in_t  stim;
        logic      typed;
        tksb_out_t want;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tksb_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tksb_out_t m_data;

    tksb_entry_t board_q[$];
    tksb_out_t   pending_results[$];
    dir_row_t    dir_rows[$];
    idle_mode_t  idle_mode    = IDLE_NONE;
    int          errors       = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;

    top_k_score_board_top #(.LIST_DEPTH(DEPTH)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Apply one transaction to the ranked-list model and return what the board must report.
    function automatic tksb_out_t board_step(input tksb_in_t t);
        tksb_out_t   r;
        tksb_entry_t e;
        int          p;
        int          k;
        r       = '0;
        p       = -1;
        k       = 0;
        e.id    = t.player_id;
        e.score = t.new_score;
        case (t.action)
            ACT_UPDATE: begin
                foreach (board_q[j])
                    if (p < 0 && board_q[j].id == t.player_id) p = j;
                if (p >= 0) begin
                    // equal scores ahead of the old position stay ahead
                    foreach (board_q[j])
                        if (j != p && (board_q[j].score > t.new_score ||
                                       (board_q[j].score == t.new_score && j < p))) k++;
                    board_q.delete(p);
                end else begin
                    foreach (board_q[j])
                        if (board_q[j].score >= t.new_score) k++;
                end
                if (k < DEPTH) begin
                    board_q.insert(k, e);
                    // drop the lowest entry once the list overflows
                    if (board_q.size() > DEPTH) board_q.delete(DEPTH);
                    r.ranked = 1'b1;
                    r.rank   = k[RANK_W-1:0];
                end
            end
            ACT_READ: begin
                if (t.slot < board_q.size()) begin
                    r.read_valid = 1'b1;
                    r.read_id    = board_q[t.slot].id;
                    r.read_score = board_q[t.slot].score;
                end
            end
            ACT_CLEAR: board_q.delete();
            default: ;
        endcase
        r.entry_count = CNT_W'(board_q.size());
        return r;
    endfunction

    function automatic tksb_out_t board_out(input int rank, input bit ranked, input int cnt,
                                            input bit rv, input logic [31:0] rid,
                                            input logic [31:0] rsc);
        tksb_out_t r;
        r.rank        = rank[RANK_W-1:0];
        r.ranked      = ranked;
        r.entry_count = cnt[CNT_W-1:0];
        r.read_valid  = rv;
        r.read_id     = rid;
        r.read_score  = rsc;
        return r;
    endfunction

    task automatic add_row(input logic [1:0] act, input logic [31:0] id,
                           input logic [31:0] score, input logic [4:0] slot,
                           input bit typed, input tksb_out_t want);
        dir_row_t row;
        row.stim.action    = act;
        row.stim.player_id = id;
        row.stim.new_score = score;
        row.stim.slot      = slot;
        row.typed          = typed;
        row.want           = want;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic send_txn(input tksb_in_t stim, input bit typed, input tksb_out_t want);
        tksb_out_t predicted;
        int        gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 81 : (idle_mode == IDLE_BOTH) ? 36 : 0;
        while ($urandom_range(99, 0) < gap_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= stim;
        do @(posedge aclk); while (!s_ready);
        predicted = board_step(stim);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    // Receiver: random stall per phase, plus one long hold-off to back up the input.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            m_ready   <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
        end else begin
            m_ready <= $urandom_range(99, 0) >= ((idle_mode == IDLE_RECV) ? 81 :
                                                 (idle_mode == IDLE_BOTH) ? 36 : 0);
        end
    end

    always @(posedge aclk) begin : result_check
        tksb_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: %h", m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.rank !== want.rank) begin
                    $error("rank: expected %0d, got %0d", want.rank, m_data.rank);
                    errors++;
                end
                if (m_data.ranked !== want.ranked) begin
                    $error("ranked: expected %0d, got %0d", want.ranked, m_data.ranked);
                    errors++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_data.entry_count);
                    errors++;
                end
                if (m_data.read_valid !== want.read_valid) begin
                    $error("read_valid: expected %0d, got %0d",
                           want.read_valid, m_data.read_valid);
                    errors++;
                end
                if (m_data.read_id !== want.read_id) begin
                    $error("read_id: expected %h, got %h", want.read_id, m_data.read_id);
                    errors++;
                end
                if (m_data.read_score !== want.read_score) begin
                    $error("read_score: expected %h, got %h",
                           want.read_score, m_data.read_score);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        tksb_in_t    stim;
        int          sent;
        int          ep_len;
        int          pool;
        int          style;
        int          pick;
        logic [31:0] id_base;

        sent = 0;
        // after reset, extremes, codes without effect
        add_row(ACT_READ,   32'h0, 32'h0, 5'd0, 1'b1, board_out(0, 0, 0, 0, 0, 0));
        add_row(ACT_NONE,   32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31, 1'b1,
                board_out(0, 0, 0, 0, 0, 0));
        add_row(ACT_CLEAR,  32'hFFFFFFFF, 32'h0, 5'd31, 1'b1, board_out(0, 0, 0, 0, 0, 0));
        add_row(ACT_UPDATE, 32'h0, 32'h0, 5'd0, 1'b1, board_out(0, 1, 1, 0, 0, 0));
        add_row(ACT_UPDATE, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31, 1'b1,
                board_out(0, 1, 2, 0, 0, 0));
        add_row(ACT_READ,   32'h0, 32'h0, 5'd0, 1'b1,
                board_out(0, 0, 2, 1, 32'hFFFFFFFF, 32'hFFFFFFFF));
        add_row(ACT_READ,   32'h0, 32'h0, 5'd1, 1'b1, board_out(0, 0, 2, 1, 0, 0));
        add_row(ACT_READ,   32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31, 1'b1,
                board_out(0, 0, 2, 0, 0, 0));
        // known id raised to a tie with the top, then re-sent unchanged
        add_row(ACT_UPDATE, 32'h0, 32'hFFFFFFFF, 5'd0, 1'b0, '0);
        add_row(ACT_UPDATE, 32'h0, 32'hFFFFFFFF, 5'd0, 1'b0, '0);
        add_row(ACT_UPDATE, 32'h5, 32'hFFFFFFFF, 5'd0, 1'b0, '0);
        add_row(ACT_UPDATE, 32'hFFFFFFFF, 32'h0, 5'd0, 1'b0, '0);
        add_row(ACT_READ,   32'h0, 32'h0, 5'd2, 1'b0, '0);
        add_row(ACT_UPDATE, 32'h55555555, 32'hAAAAAAAA, 5'h15, 1'b0, '0);
        add_row(ACT_UPDATE, 32'hAAAAAAAA, 32'h55555555, 5'h0A, 1'b0, '0);
        add_row(ACT_READ,   32'h0, 32'h0, 5'h0A, 1'b0, '0);
        add_row(ACT_READ,   32'h0, 32'h0, 5'h04, 1'b0, '0);
        add_row(ACT_CLEAR,  32'h0, 32'h0, 5'd0, 1'b1, board_out(0, 0, 0, 0, 0, 0));
        add_row(ACT_READ,   32'h0, 32'h0, 5'd0, 1'b1, board_out(0, 0, 0, 0, 0, 0));

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r])
            send_txn(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want);

        // episodes: empty the list, then mostly updates over a small id pool so it fills up
        while (sent < RANDOM_ITEMS) begin
            ep_len  = $urandom_range(120, 40);
            pool    = $urandom_range(48, 20);
            style   = $urandom_range(2, 0);
            id_base = $urandom;
            stim.action    = ACT_CLEAR;
            stim.player_id = $urandom;
            stim.new_score = $urandom;
            stim.slot      = SLOT_W'($urandom_range(31, 0));
            send_txn(stim, 1'b0, '0);
            sent++;
            for (int i = 0; i < ep_len && sent < RANDOM_ITEMS; i++) begin
                case (sent * 4 / RANDOM_ITEMS)
                    0:       idle_mode = IDLE_SEND;
                    1:       idle_mode = IDLE_RECV;
                    2:       idle_mode = IDLE_BOTH;
                    default: idle_mode = IDLE_NONE;
                endcase
                pick           = $urandom_range(99, 0);
                stim.player_id = $urandom;
                stim.new_score = $urandom;
                stim.slot      = SLOT_W'($urandom_range(31, 0));
                if (pick < 72) begin
                    stim.action = ACT_UPDATE;
                    if (pick >= 6) stim.player_id = id_base + $urandom_range(pool - 1, 0);
                    if (style == 0)
                        stim.new_score = $urandom_range(15, 0);
                    else if (style == 2)
                        stim.new_score = $urandom_range(1, 0) ?
                                         32'hFFFFFFFF - $urandom_range(1, 0) :
                                         32'($urandom_range(1, 0));
                end else if (pick < 92) begin
                    stim.action = ACT_READ;
                end else if (pick < 96) begin
                    stim.action = ACT_NONE;
                end else begin
                    stim.action = ACT_CLEAR;
                end
                send_txn(stim, 1'b0, '0);
                sent++;
            end
        end
        idle_mode = IDLE_NONE;
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
